### rtl/core/tlbpt_pkg.sv
// Shared types, widths and defaults for the TLB page-table translator.
package tlbpt_pkg;

  // Fixed field widths
  localparam int ADDR_W     = 16;
  localparam int FRAME_W    = 8;
  localparam int CNT_W      = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Page geometry: page size is a power of two, so the offset is a bit field
  localparam int PAGE_BYTES = 256;
  localparam int OFFSET_W   = $clog2(PAGE_BYTES);
  localparam int PAGE_NUM_W = ADDR_W - OFFSET_W;
  localparam int PAGE_SPAN  = 1 << PAGE_NUM_W;

  // Parameter defaults
  localparam int TLB_ENTRIES_DEF  = 16;
  localparam int PAGE_ENTRIES_DEF = 256;

  // Front-to-back queue; depth must be a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Input transfer payload
  typedef struct packed {
    logic [ADDR_W-1:0]  logical_address;
    logic [FRAME_W-1:0] fault_frame;
  } req_t;

  // Result transfer payload
  typedef struct packed {
    logic [ADDR_W-1:0]  physical_address;
    logic               tlb_hit;
    logic               page_fault;
    logic [CNT_W-1:0]   hit_total;
    logic [CNT_W-1:0]   fault_total;
    logic [CNT_W-1:0]   access_total;
  } rsp_t;

  // Classified access as held in the queue
  typedef struct packed {
    logic [PAGE_NUM_W-1:0] page;
    logic [OFFSET_W-1:0]   offset;
    logic [FRAME_W-1:0]    fault_frame;
  } qitem_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic   valid;
    qitem_t item;
  } qhead_t;

endpackage

### rtl/core/tlbpt_stream_if.sv
// Valid/ready stream channel carrying one payload of type T.
interface tlbpt_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/tlb_page_table_translator.sv
// Top level of the TLB page-table translator: front queue, back end and checks.
// A hit result is registered when the queue head is popped; a miss result is registered from S_MISS.
// Throughput: 1 item per cycle on hits while the result register is free; a miss holds the queue
//   in S_MISS for the synchronous page-table RAM read followed by the TLB/table update.
// A 2-entry queue between front and back and a result register decouple both sides.
// Reset (rst_n low, synchronous) clears valid bits, fill pointer, counters and queue.
module tlb_page_table_translator #(
  parameter int TLB_ENTRIES  = tlbpt_pkg::TLB_ENTRIES_DEF,
  parameter int PAGE_ENTRIES = tlbpt_pkg::PAGE_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  tlbpt_stream_if.sink   in_req,
  tlbpt_stream_if.source out_rsp
);

  tlbpt_pkg::qhead_t q_head;
  logic              q_pop;

  tlbpt_front #(
    .PAGE_ENTRIES (PAGE_ENTRIES)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .q_head (q_head),
    .q_pop  (q_pop)
  );

  tlbpt_back #(
    .TLB_ENTRIES  (TLB_ENTRIES),
    .PAGE_ENTRIES (PAGE_ENTRIES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_rsp (out_rsp)
  );

  // Back end never pops an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head.valid)
    else $error("queue popped while empty");

  // A hit never reports a fault
  a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && out_rsp.data.tlb_hit) |-> !out_rsp.data.page_fault)
    else $error("page fault flagged on a TLB hit");

  // Hit and fault totals never exceed the access total
  a_totals: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid |-> ((out_rsp.data.hit_total <= out_rsp.data.access_total) &&
                       (out_rsp.data.fault_total <= out_rsp.data.access_total)))
    else $error("hit or fault total above access total");

  // No result is offered right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_rsp.valid)
    else $error("result valid after reset");

endmodule

### rtl/core/tlbpt_ram.sv
// Generic simple dual-port RAM with registered read.
module tlbpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

### rtl/core/tlbpt_front.sv
// Front end: accepts addresses, splits page and offset, queues them for the back end.
module tlbpt_front #(
  parameter int PAGE_ENTRIES = tlbpt_pkg::PAGE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  tlbpt_stream_if.sink          in_req,
  output tlbpt_pkg::qhead_t     q_head,
  input  logic                  q_pop
);

  localparam int AW = tlbpt_pkg::QUEUE_AW;

  logic [tlbpt_pkg::PAGE_NUM_W-1:0] page_mod [tlbpt_pkg::PAGE_SPAN];
  tlbpt_pkg::qitem_t                mem_r [tlbpt_pkg::QUEUE_DEPTH];
  tlbpt_pkg::qitem_t                new_item;
  logic [AW-1:0]                    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]                    rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]                      count_r, count_nxt;
  logic                             push;
  logic                             pop;
  logic [tlbpt_pkg::PAGE_NUM_W-1:0] page_raw;

  // Page number modulo table size, folded at elaboration
  for (genvar g = 0; g < tlbpt_pkg::PAGE_SPAN; g++) begin : g_mod
    assign page_mod[g] = tlbpt_pkg::PAGE_NUM_W'(g % PAGE_ENTRIES);
  end

  // Classify the incoming address
  assign page_raw             = in_req.data.logical_address[tlbpt_pkg::ADDR_W-1:tlbpt_pkg::OFFSET_W];
  assign new_item.page        = page_mod[page_raw];
  assign new_item.offset      = in_req.data.logical_address[tlbpt_pkg::OFFSET_W-1:0];
  assign new_item.fault_frame = in_req.data.fault_frame;

  // Queue handshake
  assign in_req.ready = (count_r != (AW+1)'(tlbpt_pkg::QUEUE_DEPTH));
  assign push         = in_req.valid && in_req.ready;
  assign q_head.valid = (count_r != '0);
  assign q_head.item  = mem_r[rd_ptr_r];
  assign pop          = q_pop && q_head.valid;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the classified access
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

### rtl/core/tlbpt_back.sv
// Back end: TLB lookup, page-table read and fill, counters and result register.
module tlbpt_back #(
  parameter int TLB_ENTRIES  = tlbpt_pkg::TLB_ENTRIES_DEF,
  parameter int PAGE_ENTRIES = tlbpt_pkg::PAGE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tlbpt_pkg::qhead_t     q_head,
  output logic                  q_pop,
  tlbpt_stream_if.source        out_rsp
);

  // Only pages reachable from the address field are ever touched
  localparam int PT_DEPTH = (PAGE_ENTRIES < tlbpt_pkg::PAGE_SPAN) ?
                            PAGE_ENTRIES : tlbpt_pkg::PAGE_SPAN;
  localparam int PT_AW    = $clog2(PT_DEPTH);
  localparam int TLB_IW   = $clog2(TLB_ENTRIES);
  localparam int FW       = tlbpt_pkg::FRAME_W;
  localparam int CW       = tlbpt_pkg::CNT_W;

  typedef enum logic [1:0] {
    S_LOOK = 2'b01,
    S_MISS = 2'b10
  } state_t;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v == tlbpt_pkg::CNT_MAX) ? v : v + 1'b1;
  endfunction

  state_t                          state_r, state_nxt;
  logic [PT_AW-1:0]                tlb_tag_r   [TLB_ENTRIES];
  logic [FW-1:0]                   tlb_frame_r [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0]          tlb_vld_r;
  logic [TLB_ENTRIES-1:0]          tlb_match;
  logic [TLB_IW-1:0]               fill_ptr_r, fill_ptr_nxt;
  logic [PT_DEPTH-1:0]             pt_vld_r;
  logic [PT_AW-1:0]                look_page;
  logic [FW-1:0]                   hit_frame;
  logic                            look_hit;
  logic [PT_AW-1:0]                cur_page_r;
  logic [tlbpt_pkg::OFFSET_W-1:0]  cur_offset_r;
  logic [FW-1:0]                   cur_cand_r;
  logic                            cur_ptv_r;
  logic [FW-1:0]                   ram_rdata;
  logic [FW-1:0]                   miss_frame;
  logic                            fault;
  logic                            out_free;
  logic                            pop;
  logic                            load_hit;
  logic                            load_miss;
  logic                            out_valid_r, out_valid_nxt;
  tlbpt_pkg::rsp_t                 out_data_r, out_data_nxt;
  logic [CW-1:0]                   hit_cnt_r, hit_cnt_nxt;
  logic [CW-1:0]                   fault_cnt_r, fault_cnt_nxt;
  logic [CW-1:0]                   acc_cnt_r, acc_cnt_nxt;

  // Parallel compare against every TLB entry
  assign look_page = PT_AW'(q_head.item.page);

  always_comb begin
    tlb_match = '0;
    hit_frame = '0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      if (tlb_vld_r[i] && (tlb_tag_r[i] == look_page)) begin
        tlb_match[i] = 1'b1;
        hit_frame    = hit_frame | tlb_frame_r[i];
      end
    end
  end

  assign look_hit = |tlb_match;

  // Take the queue head only when the result register can hold its result
  assign out_free  = !out_valid_r || out_rsp.ready;
  assign pop       = (state_r == S_LOOK) && q_head.valid && out_free;
  assign q_pop     = pop;
  assign load_hit  = pop && look_hit;
  assign load_miss = (state_r == S_MISS);

  // Miss resolution from the page-table read
  assign fault      = !cur_ptv_r;
  assign miss_frame = fault ? cur_cand_r : ram_rdata;

  tlbpt_ram #(
    .WIDTH (FW),
    .DEPTH (PT_DEPTH)
  ) u_pt_ram (
    .clk   (clk),
    .we    (load_miss && fault),
    .waddr (cur_page_r),
    .wdata (cur_cand_r),
    .re    (pop && !look_hit),
    .raddr (look_page),
    .rdata (ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOOK: begin
        if (pop && !look_hit) begin
          state_nxt = S_MISS;
        end
      end
      S_MISS: begin
        state_nxt = S_LOOK;
      end
      default: begin
        state_nxt = S_LOOK;
      end
    endcase
  end

  // Counters and result payload
  always_comb begin
    acc_cnt_nxt   = (load_hit || load_miss) ? sat_inc(acc_cnt_r) : acc_cnt_r;
    hit_cnt_nxt   = load_hit ? sat_inc(hit_cnt_r) : hit_cnt_r;
    fault_cnt_nxt = (load_miss && fault) ? sat_inc(fault_cnt_r) : fault_cnt_r;
    fill_ptr_nxt  = fill_ptr_r;
    if (load_miss) begin
      fill_ptr_nxt = (fill_ptr_r == TLB_IW'(TLB_ENTRIES - 1)) ? '0 : fill_ptr_r + 1'b1;
    end

    out_data_nxt = out_data_r;
    if (load_hit) begin
      out_data_nxt.physical_address = tlbpt_pkg::ADDR_W'({hit_frame, q_head.item.offset});
      out_data_nxt.tlb_hit          = 1'b1;
      out_data_nxt.page_fault       = 1'b0;
    end else if (load_miss) begin
      out_data_nxt.physical_address = tlbpt_pkg::ADDR_W'({miss_frame, cur_offset_r});
      out_data_nxt.tlb_hit          = 1'b0;
      out_data_nxt.page_fault       = fault;
    end
    out_data_nxt.hit_total    = hit_cnt_nxt;
    out_data_nxt.fault_total  = fault_cnt_nxt;
    out_data_nxt.access_total = acc_cnt_nxt;

    out_valid_nxt = out_valid_r;
    if (load_hit || load_miss) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data  = out_data_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOOK;
      tlb_vld_r   <= '0;
      fill_ptr_r  <= '0;
      pt_vld_r    <= '0;
      hit_cnt_r   <= '0;
      fault_cnt_r <= '0;
      acc_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_ptr_r  <= fill_ptr_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      fault_cnt_r <= fault_cnt_nxt;
      acc_cnt_r   <= acc_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (load_miss) begin
        tlb_vld_r[fill_ptr_r] <= 1'b1;
        if (fault) begin
          pt_vld_r[cur_page_r] <= 1'b1;
        end
      end
    end
  end

  // Payload state
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (pop && !look_hit) begin
      cur_page_r   <= look_page;
      cur_offset_r <= q_head.item.offset;
      cur_cand_r   <= q_head.item.fault_frame;
      cur_ptv_r    <= pt_vld_r[look_page];
    end
    if (load_miss) begin
      tlb_tag_r[fill_ptr_r]   <= cur_page_r;
      tlb_frame_r[fill_ptr_r] <= miss_frame;
    end
  end

endmodule
